### rtl/core/int_to_padded_decimal_ascii_unit_macros.svh
// assertion helpers for the rtl core
`ifndef INT_TO_PADDED_DECIMAL_ASCII_UNIT_MACROS_SVH
`define INT_TO_PADDED_DECIMAL_ASCII_UNIT_MACROS_SVH

// same-cycle implication, clocked on i_clk, off while i_rst_n is low
`define ITPDA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, clocked on i_clk, off while i_rst_n is low
`define ITPDA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/itpda_pkg.sv
`default_nettype none

package itpda_pkg;

    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned DIGIT_W  = 4;
    localparam int unsigned NUM_DIGS = 10;
    localparam int unsigned CNT_W    = 6;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    localparam logic [CNT_W-1:0] WIDTH_RESET = 6'd15;
    localparam logic [CNT_W-1:0] WIDTH_LIMIT = 6'd32;
    localparam logic [CNT_W-1:0] WIDTH_MIN   = 6'd1;

    // ceil(2^35 / 10): exact quotient for any 32-bit dividend after >> 35
    localparam logic [VALUE_W-1:0] RECIP_10    = 32'hCCCC_CCCD;
    localparam int unsigned        RECIP_SHIFT = 35;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_REM  = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

endpackage

`default_nettype wire

### rtl/core/itpda_div10.sv
`default_nettype none

module itpda_div10 (
    input  wire logic                                i_clk,
    input  wire logic                                i_load,
    input  wire logic [itpda_pkg::VALUE_W-1:0]       i_dividend,
    output logic      [itpda_pkg::VALUE_W-1:0]       o_quot,
    output logic      [itpda_pkg::DIGIT_W-1:0]       o_rem
);

    logic [2*itpda_pkg::VALUE_W-1:0] r_prod;
    logic [itpda_pkg::VALUE_W-1:0]   r_dividend;
    logic [itpda_pkg::VALUE_W-1:0]   w_q10;
    logic [itpda_pkg::VALUE_W-1:0]   w_diff;

    // reciprocal multiply, registered before the remainder step
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod     <= {{itpda_pkg::VALUE_W{1'b0}}, i_dividend}
                        * {{itpda_pkg::VALUE_W{1'b0}}, itpda_pkg::RECIP_10};
            r_dividend <= i_dividend;
        end
    end

    assign o_quot = {{itpda_pkg::RECIP_SHIFT - itpda_pkg::VALUE_W{1'b0}},
                     r_prod[2*itpda_pkg::VALUE_W-1:itpda_pkg::RECIP_SHIFT]};

    // q * 10 as (q << 3) + (q << 1)
    assign w_q10  = {o_quot[itpda_pkg::VALUE_W-4:0], 3'b000}
                  + {o_quot[itpda_pkg::VALUE_W-2:0], 1'b0};
    assign w_diff = r_dividend - w_q10;
    assign o_rem  = w_diff[itpda_pkg::DIGIT_W-1:0];

endmodule

`default_nettype wire

### rtl/core/int_to_padded_decimal_ascii_unit.sv
// Signed 32-bit integer to zero-padded decimal ASCII. Each word on the input
// channel is converted to its decimal text, most significant character first,
// one character per output word, with o_last high on the final character and
// no terminator. Negative values (the most negative one included) start with
// '-'; zeros follow the sign until the text, sign included, is pad_width
// characters long. Longer text goes out whole. pad_width resets to 15; a
// written 0 acts as 1 and 33..63 as 32. Write it only while the block is
// idle. The value is split into digits by one shared divide-by-ten unit
// (a registered reciprocal multiply, then a remainder step), one decimal
// digit at a time, 1 to 10 digits. The characters then leave at one per
// cycle, while the receiver is ready, through the output register,
// max(pad_width, text length) of them; i_valid is taken again once the
// last character sits in the output register.
`default_nettype none

module int_to_padded_decimal_ascii_unit (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // input words
    input  wire logic                                   i_valid,
    output logic                                        o_ready,
    input  wire logic signed [itpda_pkg::VALUE_W-1:0]   i_value,
    // output words
    output logic                                        o_valid,
    input  wire logic                                   i_ready,
    output logic             [7:0]                      o_char_code,
    output logic                                        o_last,
    // configuration
    input  wire logic                                   i_cfg_valid,
    output logic                                        o_cfg_ready,
    input  wire logic        [itpda_pkg::CNT_W-1:0]     i_cfg_pad_width
);

`include "int_to_padded_decimal_ascii_unit_macros.svh"

    localparam int unsigned DW = itpda_pkg::DIGIT_W;
    localparam int unsigned CW = itpda_pkg::CNT_W;
    localparam int unsigned VW = itpda_pkg::VALUE_W;

    // control state
    itpda_pkg::t_state r_state, n_state;
    logic [CW-1:0]     r_pad;
    logic              r_out_valid, n_out_valid;

    // per-item working state
    logic              r_neg, n_neg;
    logic [VW-1:0]     r_mag, n_mag;
    logic [DW-1:0]     r_nd, n_nd;
    logic [DW-1:0]     r_digs [itpda_pkg::NUM_DIGS];
    logic [CW-1:0]     r_total, n_total;
    logic [CW-1:0]     r_pre, n_pre;
    logic [CW-1:0]     r_k, n_k;

    // output register
    logic [7:0]        r_char, n_char;
    logic              r_last, n_last;

    // divide-by-ten unit
    logic [VW-1:0]     w_quot;
    logic [DW-1:0]     w_rem;

    logic              w_accept;
    logic              w_load;
    logic [CW-1:0]     w_width;
    logic [DW-1:0]     w_nd_new;
    logic [CW-1:0]     w_text;
    logic [CW-1:0]     w_idx6;
    logic [DW-1:0]     w_digit;
    logic              w_last;

    itpda_div10 u_div10 (
        .i_clk      (i_clk),
        .i_load     (r_state == itpda_pkg::S_MUL),
        .i_dividend (r_mag),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    assign o_ready     = (r_state == itpda_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_out_valid;
    assign o_char_code = r_char;
    assign o_last      = r_last;

    assign w_accept = i_valid && o_ready;
    // next character goes in when the output register is empty or draining
    assign w_load   = (r_state == itpda_pkg::S_EMIT) && (!r_out_valid || i_ready);

    // clamp the configured width to 1..32
    always_comb begin
        priority if (r_pad == '0) begin
            w_width = itpda_pkg::WIDTH_MIN;
        end else if (r_pad > itpda_pkg::WIDTH_LIMIT) begin
            w_width = itpda_pkg::WIDTH_LIMIT;
        end else begin
            w_width = r_pad;
        end
    end

    // length bookkeeping once the final digit is known
    assign w_nd_new = r_nd + 1'b1;
    assign w_text   = {{(CW - DW){1'b0}}, w_nd_new} + {{(CW - 1){1'b0}}, r_neg};

    // digit for the current position, counted from the least significant end
    assign w_idx6  = r_total - 1'b1 - r_k;
    assign w_digit = r_digs[w_idx6[DW-1:0]];
    assign w_last  = (r_k == r_total - 1'b1);

    always_comb begin
        n_state     = r_state;
        n_neg       = r_neg;
        n_mag       = r_mag;
        n_nd        = r_nd;
        n_total     = r_total;
        n_pre       = r_pre;
        n_k         = r_k;
        n_char      = r_char;
        n_last      = r_last;
        n_out_valid = r_out_valid;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            itpda_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_neg   = i_value[VW-1];
                    n_mag   = i_value[VW-1] ? (~i_value + 1'b1) : i_value;
                    n_nd    = '0;
                    n_state = itpda_pkg::S_MUL;
                end
            end
            itpda_pkg::S_MUL: begin
                n_state = itpda_pkg::S_REM;
            end
            itpda_pkg::S_REM: begin
                n_nd  = w_nd_new;
                n_mag = w_quot;
                if (w_quot == '0) begin
                    n_total = (w_text > w_width) ? w_text : w_width;
                    n_pre   = n_total - {{(CW - DW){1'b0}}, w_nd_new};
                    n_k     = '0;
                    n_state = itpda_pkg::S_EMIT;
                end else begin
                    n_state = itpda_pkg::S_MUL;
                end
            end
            itpda_pkg::S_EMIT: begin
                if (w_load) begin
                    n_out_valid = 1'b1;
                    n_last      = w_last;
                    if (r_k < r_pre) begin
                        n_char = (r_neg && r_k == '0) ? itpda_pkg::CHAR_MINUS
                                                      : itpda_pkg::CHAR_ZERO;
                    end else begin
                        n_char = itpda_pkg::CHAR_ZERO + {{(8 - DW){1'b0}}, w_digit};
                    end
                    n_k = r_k + 1'b1;
                    if (w_last) begin
                        n_state = itpda_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = itpda_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= itpda_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_pad       <= itpda_pkg::WIDTH_RESET;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_pad <= i_cfg_pad_width;
            end
        end
    end

    // working and output registers
    always_ff @(posedge i_clk) begin
        r_neg   <= n_neg;
        r_mag   <= n_mag;
        r_nd    <= n_nd;
        r_total <= n_total;
        r_pre   <= n_pre;
        r_k     <= n_k;
        r_char  <= n_char;
        r_last  <= n_last;
    end

    // digit store, filled least significant first
    always_ff @(posedge i_clk) begin
        if (r_state == itpda_pkg::S_REM) begin
            r_digs[r_nd] <= w_rem;
        end
    end

    `ITPDA_ASSERT_IMP(a_rem_range, r_state == itpda_pkg::S_REM, w_rem < 4'd10,
        "remainder out of decimal range")
    `ITPDA_ASSERT_NXT(a_accept_mul, w_accept, r_state == itpda_pkg::S_MUL,
        "accepted word did not start conversion")
    `ITPDA_ASSERT_IMP(a_pos_bound, r_state == itpda_pkg::S_EMIT, r_k < r_total,
        "character position past text length")
    `ITPDA_ASSERT_IMP(a_digit_idx, w_load && (r_k >= r_pre),
        w_idx6 < {{(CW - DW){1'b0}}, r_nd}, "digit index beyond stored digits")
    `ITPDA_ASSERT_NXT(a_last_idle, w_load && w_last,
        (r_state == itpda_pkg::S_IDLE) && o_valid && o_last,
        "final character did not close the text")

endmodule

`default_nettype wire

### tb/tb_int_to_padded_decimal_ascii_unit.sv
`timescale 1ns / 1ps

// one expected output word: character code and end-of-text flag
typedef struct packed {
    logic [7:0] code;
    logic       last;
} t_char_word;

// expected character stream for every accepted value, checked in order
class decimal_text_board;
    t_char_word                       pending_chars[$];
    logic [itpda_pkg::CNT_W-1:0]      pad_width;
    int                               errors;
    int                               values_seen;
    int                               words_checked;

    function new();
        pad_width     = itpda_pkg::WIDTH_RESET;
        errors        = 0;
        values_seen   = 0;
        words_checked = 0;
    endfunction

    function void set_width(logic [itpda_pkg::CNT_W-1:0] w);
        pad_width = w;
    endfunction

    function int pending();
        return pending_chars.size();
    endfunction

    // expand one value into its padded decimal text, one word per character
    function void expand_value(logic [itpda_pkg::VALUE_W-1:0] v);
        logic [31:0] mag;
        int          digs[10];
        int          nd;
        int          text_len;
        int          w;
        int          total;
        t_char_word  cw;
        logic        neg;
        neg = v[31];
        mag = neg ? (~v + 32'd1) : v;
        nd  = 0;
        do begin
            digs[nd] = mag % 10;
            nd++;
            mag = mag / 10;
        end while (mag != 0);
        text_len = nd + (neg ? 1 : 0);
        w = pad_width;
        if (w > itpda_pkg::WIDTH_LIMIT) w = itpda_pkg::WIDTH_LIMIT;
        if (w < itpda_pkg::WIDTH_MIN) w = itpda_pkg::WIDTH_MIN;
        total = (text_len > w) ? text_len : w;
        for (int k = 0; k < total; k++) begin
            if (neg && k == 0)
                cw.code = itpda_pkg::CHAR_MINUS;
            else if (k < total - nd)
                cw.code = itpda_pkg::CHAR_ZERO;
            else
                cw.code = itpda_pkg::CHAR_ZERO + 8'(digs[total - 1 - k]);
            cw.last = (k == total - 1);
            pending_chars.push_back(cw);
        end
        values_seen++;
    endfunction

    function void check_word(logic [7:0] code, logic last);
        t_char_word exp_w;
        if (pending_chars.size() == 0) begin
            if (errors < 10)
                $display("unexpected word: code %h last %b, nothing pending", code, last);
            errors++;
        end else begin
            exp_w = pending_chars.pop_front();
            if (exp_w.code !== code || exp_w.last !== last) begin
                if (errors < 10)
                    $display("mismatch at word %0d: expected code %h last %b, got code %h last %b",
                             words_checked, exp_w.code, exp_w.last, code, last);
                errors++;
            end
        end
        words_checked++;
    endfunction
endclass

module tb_int_to_padded_decimal_ascii_unit;

    localparam int RESET_CYCLES  = 7;
    localparam int SETTLE_CYCLES = 8;
    localparam int END_CYCLES    = 40;
    localparam int LONG_HOLD     = 200;
    localparam int PHASE_ITEMS   = 35;

    // receiver stall patterns
    typedef enum int {
        READY_ALWAYS,
        READY_COIN,
        READY_SPARSE
    } t_ready_mode;

    logic                                    i_clk = 1'b0;
    logic                                    i_rst_n = 1'b0;
    logic                                    i_valid = 1'b0;
    logic                                    o_ready;
    logic signed [itpda_pkg::VALUE_W-1:0]    i_value = '0;
    logic                                    o_valid;
    logic                                    i_ready = 1'b0;
    logic        [7:0]                       o_char_code;
    logic                                    o_last;
    logic                                    i_cfg_valid = 1'b0;
    logic                                    o_cfg_ready;
    logic        [itpda_pkg::CNT_W-1:0]      i_cfg_pad_width = '0;

    decimal_text_board board;

    // receiver control: the long hold-off is requested here, counted down below
    logic          hold_request = 1'b0;
    int            hold_left = 0;
    int            mode_left = 0;
    t_ready_mode   ready_mode = READY_ALWAYS;
    int            widths_used = 1;

    int_to_padded_decimal_ascii_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_value         (i_value),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_char_code     (o_char_code),
        .o_last          (o_last),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_pad_width (i_cfg_pad_width)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // output side: check each accepted word, then pick next ready level
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready)
                board.check_word(o_char_code, o_last);
            if (hold_request) begin
                hold_left = LONG_HOLD;
                hold_request <= 1'b0;
            end
            // switch stall pattern every so often
            if (mode_left == 0) begin
                mode_left  = $urandom_range(20, 120);
                ready_mode = t_ready_mode'($urandom_range(0, 2));
            end else begin
                mode_left--;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                case (ready_mode)
                    READY_ALWAYS: i_ready <= 1'b1;
                    READY_COIN:   i_ready <= 1'($urandom_range(0, 1));
                    default:      i_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // mix of full-range, sized, small, boundary and near-power-of-ten values
    function automatic logic [31:0] pick_value();
        logic [31:0] mag;
        int unsigned lo;
        int unsigned hi;
        int          n;
        logic        neg;
        neg = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom();
            4, 5, 6: begin
                // magnitude with a chosen number of digits
                n  = $urandom_range(1, 10);
                lo = 1;
                repeat (n - 1) lo = lo * 10;
                if (n == 10)
                    hi = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
                else
                    hi = lo * 10 - 1;
                mag = $urandom_range(hi, lo);
            end
            7: mag = $urandom_range(0, 20);
            8: begin
                case ($urandom_range(0, 3))
                    0:       mag = 32'd0;
                    1:       mag = 32'd1;
                    2:       mag = 32'h7FFF_FFFF;
                    default: mag = 32'h8000_0000;
                endcase
            end
            default: begin
                // just around a power of ten, where the digit count changes
                n  = $urandom_range(0, 9);
                lo = 1;
                repeat (n) lo = lo * 10;
                mag = lo + $urandom_range(0, 2) - 1;
            end
        endcase
        return neg ? (~mag + 32'd1) : mag;
    endfunction

    // offer one word, hold it until taken
    task automatic send_value(logic [31:0] v);
        i_valid <= 1'b1;
        i_value <= v;
        do @(posedge i_clk); while (!o_ready);
        board.expand_value(v);
    endtask

    task automatic drop_valid_for(int cycles);
        i_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (board.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_width(logic [itpda_pkg::CNT_W-1:0] w);
        i_cfg_valid     <= 1'b1;
        i_cfg_pad_width <= w;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        board.set_width(w);
        widths_used++;
    endtask

    // random words in bursts; each run opens with the longest text and zero
    task automatic send_values(int count, bit long_hold, bit mid_pause);
        int burst_left;
        int gap;
        logic [31:0] v;
        burst_left = 0;
        for (int i = 0; i < count; i++) begin
            if (long_hold && i == 5)
                hold_request <= 1'b1;
            if (mid_pause && i == count / 2) begin
                // sender waits until every expected word is back
                i_valid <= 1'b0;
                wait_drained();
            end
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 10);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                if (gap > 0)
                    drop_valid_for(gap);
            end
            if (i == 0)
                v = 32'h8000_0000;
            else if (i == 1)
                v = 32'd0;
            else
                v = pick_value();
            send_value(v);
            burst_left--;
        end
        i_valid <= 1'b0;
    endtask

    logic [31:0]      directed_vals[] = '{
        32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, -32'sd9, 32'd10, -32'sd10, 32'd99,
        32'd100, 32'd12345, -32'sd12345, 32'd999999999, 32'd1000000000,
        -32'sd1000000000, 32'h7FFF_FFFF, 32'h8000_0001, 32'h8000_0000,
        32'h5555_5555, 32'hAAAA_AAAA, 32'd1234567890
    };
    // minimum, zero, limit, both saturating widths, text-length edges
    logic [itpda_pkg::CNT_W-1:0] phase_widths[] = '{
        6'd1, 6'd0, 6'd32, 6'd63, 6'd33, 6'd11, 6'd12, 6'd2, 6'd20
    };

    initial begin
        board = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed words at the reset width, short gaps between some
        foreach (directed_vals[i]) begin
            if ($urandom_range(0, 2) == 0)
                drop_valid_for($urandom_range(1, 4));
            send_value(directed_vals[i]);
        end
        i_valid <= 1'b0;
        wait_drained();

        phase_widths[8] = itpda_pkg::CNT_W'($urandom_range(3, 31));
        foreach (phase_widths[p]) begin
            write_width(phase_widths[p]);
            // long receiver hold-off at full width, sender pause mid-run later on
            send_values(PHASE_ITEMS, p == 2, p == 4);
            wait_drained();
        end

        while (board.pending() != 0) @(posedge i_clk);
        repeat (END_CYCLES) @(posedge i_clk);

        $display("converted %0d values into %0d characters across %0d pad widths",
                 board.values_seen, board.words_checked, widths_used);
        $display("included saturated and zero widths and a %0d-cycle output hold-off",
                 LONG_HOLD);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d errors, %0d words outstanding", board.errors, board.pending());
            $display("== FAIL ==");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("timeout");
        $display("== FAIL ==");
        $finish;
    end

endmodule
